@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define HKMG_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define HKMG_ASSERT(lbl, prop, msg) \
    `HKMG_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)

`endif

@@ rtl/core/hkmg_pkg.sv @@
`default_nettype none

package hkmg_pkg;

    localparam int WIDTH  = 640;
    localparam int HEIGHT = 480;
    localparam int NCX    = (WIDTH - 2) / 2;
    localparam int NCY    = (HEIGHT - 2) / 2;

    localparam int CI_W   = $clog2(NCX);
    localparam int CJ_W   = $clog2(NCY);
    localparam int MAP_AW = CI_W + CJ_W;

    localparam int PIX_XW = 10;
    localparam int PIX_YW = 9;
    localparam int PICK_W = 5;
    localparam int ORD_W  = 8;
    localparam int NPERM  = 24;

    localparam logic [CI_W-1:0] LAST_CI = CI_W'(NCX - 1);
    localparam logic [CJ_W-1:0] LAST_CJ = CJ_W'(NCY - 1);

    typedef logic [CI_W-1:0] ci_t;
    typedef logic [CJ_W-1:0] cj_t;

    typedef enum logic [1:0] {
        DIR_XP = 2'd0,
        DIR_YP = 2'd1,
        DIR_XN = 2'd2,
        DIR_YN = 2'd3
    } dir_t;

    typedef enum logic {
        CMD_RESTART = 1'b0,
        CMD_STEP    = 1'b1
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXT_PROBE,
        ST_EXT_CHECK,
        ST_HUNT_RD,
        ST_HUNT_CHK,
        ST_NB_PROBE,
        ST_NB_CHECK,
        ST_LINK_PROBE,
        ST_LINK_CHECK,
        ST_EMIT0,
        ST_EMIT1
    } st_t;

    typedef struct packed {
        logic              wr_en;
        logic [MAP_AW-1:0] wr_addr;
        logic              wr_data;
        logic [MAP_AW-1:0] rd_addr;
    } map_req_t;

    typedef struct packed {
        logic ok;
        ci_t  i;
        cj_t  j;
    } nbr_t;

    localparam logic [ORD_W-1:0] PERM_TABLE [NPERM] = '{
        8'd27,  8'd30,  8'd39,  8'd45,  8'd54,  8'd57,  8'd75,  8'd78,
        8'd99,  8'd108, 8'd114, 8'd120, 8'd135, 8'd141, 8'd147, 8'd156,
        8'd177, 8'd180, 8'd198, 8'd201, 8'd210, 8'd216, 8'd225, 8'd228
    };

    // Indices beyond the table give the all-zero order, i.e. +x four times.
    function automatic logic [ORD_W-1:0] order_of(input logic [PICK_W-1:0] pick);
        logic [ORD_W-1:0] ord;
        ord = '0;
        if (pick < PICK_W'(NPERM)) begin
            ord = PERM_TABLE[pick];
        end
        return ord;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/hkmg_map.sv @@
`default_nettype none

module hkmg_map
    import hkmg_pkg::*;
(
    input  wire logic     aclk,
    input  wire map_req_t req,
    output logic          rd_data
);

    logic visited_mem [2**MAP_AW];
    logic rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            visited_mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= visited_mem[req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/hkmg_nbr.sv @@
`default_nettype none

module hkmg_nbr
    import hkmg_pkg::*;
(
    input  wire ci_t  base_i,
    input  wire cj_t  base_j,
    input  wire dir_t dir,
    output nbr_t      nbr
);

    always_comb begin
        nbr.ok = 1'b0;
        nbr.i  = base_i;
        nbr.j  = base_j;
        unique case (dir)
            DIR_XP: begin
                nbr.ok = (base_i != LAST_CI);
                nbr.i  = base_i + ci_t'(1);
            end
            DIR_YP: begin
                nbr.ok = (base_j != LAST_CJ);
                nbr.j  = base_j + cj_t'(1);
            end
            DIR_XN: begin
                nbr.ok = (base_i != '0);
                nbr.i  = base_i - ci_t'(1);
            end
            DIR_YN: begin
                nbr.ok = (base_j != '0);
                nbr.j  = base_j - cj_t'(1);
            end
            default: begin
                nbr.ok = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/hunt_and_kill_maze_generator.sv @@
`default_nettype none

// Hunt-and-kill maze carver on a 640 by 480 pixel grid with cells at odd
// coordinates. A step transaction (cmd 1) yields one or two pixels to draw in
// path colour, or nothing once the maze is complete; a restart transaction
// (cmd 0) yields nothing and starts a clearing pass over the NCX*NCY = 76241
// cells of the visited map, during which s_ready is low; the same pass runs
// after reset. The single read port of the visited map, which one neighbour
// unit shares, sets the pace: an extend step probes the four directions in
// turn, reading the map for each in-bound neighbour, before its first pixel is
// offered; a hunt step scans cells in order and tests the in-bound neighbours
// of each unvisited cell; the link search then probes the directions of the
// new cell. Each result then passes into the output register, which stalls
// only while the consumer holds m_ready low.
module hunt_and_kill_maze_generator
    import hkmg_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_cmd,
    input  wire logic [PICK_W-1:0] s_pick_walk,
    input  wire logic [PICK_W-1:0] s_pick_link,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [PIX_XW-1:0]      m_pixel_x,
    output logic [PIX_YW-1:0]      m_pixel_y,
    output logic                   m_last,
    output logic                   m_done_res
);

    st_t              state_reg, state_next;
    ci_t              cur_i_reg, cur_i_next;
    cj_t              cur_j_reg, cur_j_next;
    ci_t              hunt_i_reg, hunt_i_next;
    cj_t              hunt_j_reg, hunt_j_next;
    ci_t              scan_i_reg, scan_i_next;
    cj_t              scan_j_reg, scan_j_next;
    ci_t              nb_i_reg, nb_i_next;
    cj_t              nb_j_reg, nb_j_next;
    ci_t              e0_i_reg, e0_i_next;
    cj_t              e0_j_reg, e0_j_next;
    logic             finished_reg, finished_next;
    logic             tally_reg, tally_next;
    logic [1:0]       k_reg, k_next;
    logic [ORD_W-1:0] walk_ord_reg, walk_ord_next;
    logic [ORD_W-1:0] link_ord_reg, link_ord_next;
    logic [PIX_XW-1:0] wall_x_reg, wall_x_next;
    logic [PIX_YW-1:0] wall_y_reg, wall_y_next;
    logic             has_wall_reg, has_wall_next;
    logic             done_reg, done_next;

    logic              m_valid_reg, m_valid_next;
    logic [PIX_XW-1:0] m_pixel_x_reg, m_pixel_x_next;
    logic [PIX_YW-1:0] m_pixel_y_reg, m_pixel_y_next;
    logic              m_last_reg, m_last_next;
    logic              m_done_reg, m_done_next;

    map_req_t map_req;
    logic     map_rd;
    ci_t      base_i;
    cj_t      base_j;
    dir_t     dir;
    nbr_t     nbr;
    logic     s_take;
    logic     out_free;
    logic     scan_row_end;
    logic     scan_grid_end;

    hkmg_map u_map (
        .aclk    (aclk),
        .req     (map_req),
        .rd_data (map_rd)
    );

    hkmg_nbr u_nbr (
        .base_i (base_i),
        .base_j (base_j),
        .dir    (dir),
        .nbr    (nbr)
    );

    assign s_ready       = (state_reg == ST_IDLE);
    assign s_take        = s_valid && s_ready;
    assign out_free      = !m_valid_reg || m_ready;
    assign scan_row_end  = (scan_i_reg == LAST_CI);
    assign scan_grid_end = scan_row_end && (scan_j_reg == LAST_CJ);

    // The neighbour unit serves the extend, hunt and link searches in turn.
    always_comb begin
        base_i = cur_i_reg;
        base_j = cur_j_reg;
        dir    = dir_t'(walk_ord_reg[{k_reg, 1'b0} +: 2]);
        if (state_reg == ST_NB_PROBE) begin
            base_i = scan_i_reg;
            base_j = scan_j_reg;
            dir    = dir_t'(k_reg);
        end else if (state_reg == ST_LINK_PROBE) begin
            dir    = dir_t'(link_ord_reg[{k_reg, 1'b0} +: 2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cur_i_reg    <= '0;
            cur_j_reg    <= '0;
            hunt_i_reg   <= '0;
            hunt_j_reg   <= '0;
            scan_i_reg   <= '0;
            scan_j_reg   <= '0;
            finished_reg <= 1'b0;
            tally_reg    <= 1'b0;
            k_reg        <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_i_reg    <= cur_i_next;
            cur_j_reg    <= cur_j_next;
            hunt_i_reg   <= hunt_i_next;
            hunt_j_reg   <= hunt_j_next;
            scan_i_reg   <= scan_i_next;
            scan_j_reg   <= scan_j_next;
            finished_reg <= finished_next;
            tally_reg    <= tally_next;
            k_reg        <= k_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        nb_i_reg      <= nb_i_next;
        nb_j_reg      <= nb_j_next;
        e0_i_reg      <= e0_i_next;
        e0_j_reg      <= e0_j_next;
        walk_ord_reg  <= walk_ord_next;
        link_ord_reg  <= link_ord_next;
        wall_x_reg    <= wall_x_next;
        wall_y_reg    <= wall_y_next;
        has_wall_reg  <= has_wall_next;
        done_reg      <= done_next;
        m_pixel_x_reg <= m_pixel_x_next;
        m_pixel_y_reg <= m_pixel_y_next;
        m_last_reg    <= m_last_next;
        m_done_reg    <= m_done_next;
    end

    always_comb begin
        state_next     = state_reg;
        cur_i_next     = cur_i_reg;
        cur_j_next     = cur_j_reg;
        hunt_i_next    = hunt_i_reg;
        hunt_j_next    = hunt_j_reg;
        scan_i_next    = scan_i_reg;
        scan_j_next    = scan_j_reg;
        nb_i_next      = nb_i_reg;
        nb_j_next      = nb_j_reg;
        e0_i_next      = e0_i_reg;
        e0_j_next      = e0_j_reg;
        finished_next  = finished_reg;
        tally_next     = tally_reg;
        k_next         = k_reg;
        walk_ord_next  = walk_ord_reg;
        link_ord_next  = link_ord_reg;
        wall_x_next    = wall_x_reg;
        wall_y_next    = wall_y_reg;
        has_wall_next  = has_wall_reg;
        done_next      = done_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_pixel_x_next = m_pixel_x_reg;
        m_pixel_y_next = m_pixel_y_reg;
        m_last_next    = m_last_reg;
        m_done_next    = m_done_reg;

        map_req.wr_en   = 1'b0;
        map_req.wr_addr = {cur_j_reg, cur_i_reg};
        map_req.wr_data = 1'b1;
        map_req.rd_addr = {nbr.j, nbr.i};

        unique case (state_reg)
            ST_CLEAR: begin
                map_req.wr_en   = 1'b1;
                map_req.wr_addr = {scan_j_reg, scan_i_reg};
                map_req.wr_data = 1'b0;
                scan_i_next     = scan_row_end ? '0 : scan_i_reg + ci_t'(1);
                scan_j_next     = scan_row_end ? scan_j_reg + cj_t'(1) : scan_j_reg;
                if (scan_grid_end) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (s_take) begin
                    if (cmd_t'(s_cmd) == CMD_RESTART) begin
                        cur_i_next    = '0;
                        cur_j_next    = '0;
                        hunt_i_next   = '0;
                        hunt_j_next   = '0;
                        scan_i_next   = '0;
                        scan_j_next   = '0;
                        finished_next = 1'b0;
                        state_next    = ST_CLEAR;
                    end else if (!finished_reg) begin
                        // Mark the current cell as it is drawn.
                        map_req.wr_en = 1'b1;
                        walk_ord_next = order_of(s_pick_walk);
                        link_ord_next = order_of(s_pick_link);
                        k_next        = '0;
                        state_next    = ST_EXT_PROBE;
                    end
                end
            end

            ST_EXT_PROBE: begin
                nb_i_next = nbr.i;
                nb_j_next = nbr.j;
                if (nbr.ok) begin
                    state_next = ST_EXT_CHECK;
                end else if (k_reg == 2'd3) begin
                    scan_i_next = hunt_i_reg;
                    scan_j_next = hunt_j_reg;
                    tally_next  = 1'b1;
                    state_next  = ST_HUNT_RD;
                end else begin
                    k_next = k_reg + 2'd1;
                end
            end

            ST_EXT_CHECK: begin
                if (!map_rd) begin
                    e0_i_next     = cur_i_reg;
                    e0_j_next     = cur_j_reg;
                    wall_x_next   = PIX_XW'(cur_i_reg) + PIX_XW'(nb_i_reg) + PIX_XW'(1);
                    wall_y_next   = PIX_YW'(cur_j_reg) + PIX_YW'(nb_j_reg) + PIX_YW'(1);
                    has_wall_next = 1'b1;
                    done_next     = 1'b0;
                    cur_i_next    = nb_i_reg;
                    cur_j_next    = nb_j_reg;
                    state_next    = ST_EMIT0;
                end else if (k_reg == 2'd3) begin
                    scan_i_next = hunt_i_reg;
                    scan_j_next = hunt_j_reg;
                    tally_next  = 1'b1;
                    state_next  = ST_HUNT_RD;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_EXT_PROBE;
                end
            end

            ST_HUNT_RD: begin
                map_req.rd_addr = {scan_j_reg, scan_i_reg};
                state_next      = ST_HUNT_CHK;
            end

            ST_HUNT_CHK: begin
                if (map_rd) begin
                    // The hunt origin follows the leading run of visited cells.
                    if (tally_reg) begin
                        hunt_i_next = scan_i_reg;
                        hunt_j_next = scan_j_reg;
                    end
                end else begin
                    tally_next = 1'b0;
                    k_next     = '0;
                    state_next = ST_NB_PROBE;
                end
            end

            ST_NB_PROBE: begin
                nb_i_next = nbr.i;
                nb_j_next = nbr.j;
                if (nbr.ok) begin
                    state_next = ST_NB_CHECK;
                end else if (k_reg != 2'd3) begin
                    k_next = k_reg + 2'd1;
                end
            end

            ST_NB_CHECK: begin
                if (map_rd) begin
                    e0_i_next  = cur_i_reg;
                    e0_j_next  = cur_j_reg;
                    cur_i_next = scan_i_reg;
                    cur_j_next = scan_j_reg;
                    done_next  = 1'b0;
                    k_next     = '0;
                    state_next = ST_LINK_PROBE;
                end else if (k_reg != 2'd3) begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_NB_PROBE;
                end
            end

            ST_LINK_PROBE: begin
                nb_i_next = nbr.i;
                nb_j_next = nbr.j;
                if (nbr.ok) begin
                    state_next = ST_LINK_CHECK;
                end else if (k_reg == 2'd3) begin
                    has_wall_next = 1'b0;
                    state_next    = ST_EMIT0;
                end else begin
                    k_next = k_reg + 2'd1;
                end
            end

            ST_LINK_CHECK: begin
                if (map_rd) begin
                    wall_x_next   = PIX_XW'(cur_i_reg) + PIX_XW'(nb_i_reg) + PIX_XW'(1);
                    wall_y_next   = PIX_YW'(cur_j_reg) + PIX_YW'(nb_j_reg) + PIX_YW'(1);
                    has_wall_next = 1'b1;
                    state_next    = ST_EMIT0;
                end else if (k_reg == 2'd3) begin
                    has_wall_next = 1'b0;
                    state_next    = ST_EMIT0;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_LINK_PROBE;
                end
            end

            ST_EMIT0: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_pixel_x_next = PIX_XW'({e0_i_reg, 1'b1});
                    m_pixel_y_next = PIX_YW'({e0_j_reg, 1'b1});
                    m_last_next    = !has_wall_reg;
                    m_done_next    = done_reg;
                    state_next     = has_wall_reg ? ST_EMIT1 : ST_IDLE;
                end
            end

            ST_EMIT1: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_pixel_x_next = wall_x_reg;
                    m_pixel_y_next = wall_y_reg;
                    m_last_next    = 1'b1;
                    m_done_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A visited cell, or an unvisited cell with no visited neighbour, sends the scan onwards;
        // running off the last row completes the maze.
        if ((state_reg == ST_HUNT_CHK && map_rd) ||
            (state_reg == ST_NB_PROBE && !nbr.ok && k_reg == 2'd3) ||
            (state_reg == ST_NB_CHECK && !map_rd && k_reg == 2'd3)) begin
            if (scan_grid_end) begin
                e0_i_next     = cur_i_reg;
                e0_j_next     = cur_j_reg;
                has_wall_next = 1'b0;
                done_next     = 1'b1;
                finished_next = 1'b1;
                state_next    = ST_EMIT0;
            end else begin
                scan_i_next = scan_row_end ? '0 : scan_i_reg + ci_t'(1);
                scan_j_next = scan_row_end ? scan_j_reg + cj_t'(1) : scan_j_reg;
                state_next  = ST_HUNT_RD;
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_pixel_x  = m_pixel_x_reg;
    assign m_pixel_y  = m_pixel_y_reg;
    assign m_last     = m_last_reg;
    assign m_done_res = m_done_reg;

endmodule

`default_nettype wire

@@ rtl/core/hkmg_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module hkmg_checker
    import hkmg_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              s_cmd,
    input wire logic [PICK_W-1:0] s_pick_walk,
    input wire logic [PICK_W-1:0] s_pick_link,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [PIX_XW-1:0] m_pixel_x,
    input wire logic [PIX_YW-1:0] m_pixel_y,
    input wire logic              m_last,
    input wire logic              m_done_res
);

    logic [PIX_XW+PIX_YW+1:0] m_payload;
    logic [PICK_W*2:0]        s_payload;
    logic                     cell_pix;
    logic                     pix_in_grid;

    assign m_payload   = {m_pixel_x, m_pixel_y, m_last, m_done_res};
    assign s_payload   = {s_cmd, s_pick_walk, s_pick_link};
    assign cell_pix    = m_pixel_x[0] && m_pixel_y[0];
    assign pix_in_grid = (m_pixel_x < PIX_XW'(WIDTH)) && (m_pixel_y < PIX_YW'(HEIGHT));

    // A stalled input transaction holds its payload.
    `HKMG_ASSERT(a_in_hold, s_valid && !s_ready |=> s_valid && $stable(s_payload), "input not held")

    // A stalled result transaction holds its payload.
    `HKMG_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_payload), "result not held")

    // Completion is reported only on the closing pixel of a step.
    `HKMG_ASSERT(a_done_last, m_valid && m_done_res |-> m_last, "done_res without last")

    // The first pixel of a two-pixel step is always a cell, at odd coordinates.
    `HKMG_ASSERT(a_cell_odd, m_valid && !m_last |-> cell_pix, "first pixel is not a cell")

    // Every pixel drawn lies inside the grid.
    `HKMG_ASSERT(a_in_grid, m_valid |-> pix_in_grid, "pixel outside the grid")

endmodule

bind hunt_and_kill_maze_generator hkmg_checker u_hkmg_checker (.*);

`default_nettype wire
